>>> hdl/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and round functions of the SM3 hash core.
// ----------------------------------------------------------------------------
package sm3_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] state_t;     // index 0 is word A
	typedef logic [15:0][31:0] window_t;   // index 0 is the oldest word

	localparam int CFG_INDEX_W     = 3;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam word_t T_LOW  = 32'h79CC4519;
	localparam word_t T_HIGH = 32'h7A879D8A;

	localparam state_t IV_STD = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	// item classes, decided when the word is taken
	typedef enum logic [1:0] {
		KIND_WORD,    // word inside a block
		KIND_BLOCK,   // word completes a block, message goes on
		KIND_DIGEST,  // word completes a block and ends the message
		KIND_SHORT    // message ends inside a block
	} kind_t;

	typedef struct packed {
		word_t message_word;
		logic  first_word;
		logic  last_word;
	} sm3_in_t;

	typedef struct packed {
		logic [63:0] digest_part_0;
		logic [63:0] digest_part_1;
		logic [63:0] digest_part_2;
		logic [63:0] digest_part_3;
		logic        length_error;
	} sm3_out_t;

	typedef struct packed {
		word_t word;
		logic  first;
		kind_t kind;
	} sm3_item_t;

	function automatic word_t rotl(word_t x, logic [4:0] n);
		logic [63:0] tmp;
		tmp = {x, x} << n;
		return tmp[63:32];
	endfunction

	function automatic word_t p0(word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t p1(word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// rotated round constant, a 64-entry constant table after folding
	function automatic word_t t_rot(logic [5:0] j);
		return rotl((j[5:4] == 2'b00) ? T_LOW : T_HIGH, j[4:0]);
	endfunction

	// next expanded word W[j+16] from the window W[j..j+15]
	function automatic word_t expand(window_t w);
		return p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
	endfunction

	function automatic state_t sm3_round(state_t r, word_t w0, word_t wp, logic [5:0] j);
		word_t  a12;
		word_t  ss1;
		word_t  ss2;
		word_t  ff;
		word_t  gg;
		word_t  tt1;
		word_t  tt2;
		state_t n;
		a12 = rotl(r[0], 5'd12);
		ss1 = rotl(a12 + r[4] + t_rot(j), 5'd7);
		ss2 = ss1 ^ a12;
		if (j[5:4] == 2'b00) begin
			ff = r[0] ^ r[1] ^ r[2];
			gg = r[4] ^ r[5] ^ r[6];
		end else begin
			ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
			gg = (r[4] & r[5]) | (~r[4] & r[6]);
		end
		tt1  = ff + r[3] + ss2 + wp;
		tt2  = gg + r[7] + ss1 + w0;
		n[3] = r[2];
		n[2] = rotl(r[1], 5'd9);
		n[1] = r[0];
		n[0] = tt1;
		n[7] = r[6];
		n[6] = rotl(r[5], 5'd19);
		n[5] = r[4];
		n[4] = p0(tt2);
		return n;
	endfunction

endpackage

>>> hdl/sm3_front.sv
// ----------------------------------------------------------------------------
// sm3_front
// Takes message words, tracks the block position, tags each word with its
// class and queues it for the compression engine.
// ----------------------------------------------------------------------------
module sm3_front #(
	parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sm3_pkg::sm3_in_t    msg,
	output logic                item_valid,
	input  logic                item_ready,
	output sm3_pkg::sm3_item_t  item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sm3_pkg::sm3_item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [3:0]         pos_q;

	logic               wr_en;
	logic               rd_en;
	logic [3:0]         eff_pos;
	logic               complete;
	sm3_pkg::sm3_item_t new_item;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_valid && item_ready;

	// a first word restarts the block position
	assign eff_pos  = msg.first_word ? 4'd0 : pos_q;
	assign complete = (eff_pos == 4'd15);

	always_comb begin
		new_item.word  = msg.message_word;
		new_item.first = msg.first_word;
		if (msg.last_word) begin
			new_item.kind = complete ? sm3_pkg::KIND_DIGEST : sm3_pkg::KIND_SHORT;
		end else begin
			new_item.kind = complete ? sm3_pkg::KIND_BLOCK : sm3_pkg::KIND_WORD;
		end
	end

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			pos_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
				pos_q    <= msg.last_word ? 4'd0 : eff_pos + 4'd1;
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

>>> hdl/sm3_engine.sv
// ----------------------------------------------------------------------------
// sm3_engine
// Loads queued words into the expansion window, runs 64 rounds per block
// with one round unit, folds the result into the chaining value and holds
// one result for the output side.
// ----------------------------------------------------------------------------
module sm3_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  sm3_pkg::state_t     iv,
	input  logic                item_valid,
	output logic                item_ready,
	input  sm3_pkg::sm3_item_t  item,
	output logic                empty,
	input  logic                pop,
	output sm3_pkg::sm3_out_t   digest
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_EMIT
	} fsm_state_t;

	fsm_state_t          state_q;
	logic [5:0]          j_q;
	logic                last_q;
	logic                out_valid_q;
	sm3_pkg::sm3_out_t   out_q;
	sm3_pkg::state_t     cv_q;
	sm3_pkg::state_t     r_q;
	sm3_pkg::window_t    w_q;

	logic                out_free;
	logic                take;
	logic                round_en;
	logic                short_take;
	logic                emit_fire;
	sm3_pkg::state_t     r_next;
	sm3_pkg::word_t      w_new;

	assign out_free   = !out_valid_q || pop;
	assign item_ready = (state_q == ST_IDLE) &&
	                    ((item.kind != sm3_pkg::KIND_SHORT) || out_free);
	assign take       = item_valid && item_ready;
	assign round_en   = (state_q == ST_ROUND);
	assign short_take = take && (item.kind == sm3_pkg::KIND_SHORT);
	assign emit_fire  = (state_q == ST_EMIT) && out_free;
	assign r_next     = sm3_pkg::sm3_round(r_q, w_q[0], w_q[0] ^ w_q[4], j_q);
	assign w_new      = sm3_pkg::expand(w_q);
	assign empty      = !out_valid_q;
	assign digest     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			cv_q        <= sm3_pkg::IV_STD;
		end else begin
			// a new result wins over the pop of the old one
			if (short_take || emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (item.first) begin
							cv_q <= iv;
						end
						unique case (item.kind)
							sm3_pkg::KIND_WORD: begin
							end
							sm3_pkg::KIND_BLOCK: begin
								j_q     <= '0;
								last_q  <= 1'b0;
								state_q <= ST_ROUND;
							end
							sm3_pkg::KIND_DIGEST: begin
								j_q     <= '0;
								last_q  <= 1'b1;
								state_q <= ST_ROUND;
							end
							sm3_pkg::KIND_SHORT: begin
								out_q <= '{digest_part_0: 64'd0, digest_part_1: 64'd0,
								           digest_part_2: 64'd0, digest_part_3: 64'd0,
								           length_error: 1'b1};
							end
							default: begin
							end
						endcase
					end
				end
				ST_ROUND: begin
					j_q <= j_q + 6'd1;
					if (j_q == 6'd63) begin
						cv_q    <= cv_q ^ r_next;   // feed-forward
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_q.digest_part_0 <= {cv_q[0], cv_q[1]};
						out_q.digest_part_1 <= {cv_q[2], cv_q[3]};
						out_q.digest_part_2 <= {cv_q[4], cv_q[5]};
						out_q.digest_part_3 <= {cv_q[6], cv_q[7]};
						out_q.length_error  <= 1'b0;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window shifts down: loaded words during fill, expanded words during rounds
	always_ff @(posedge clk) begin
		if (take) begin
			w_q <= {item.word, w_q[15:1]};
			r_q <= item.first ? iv : cv_q;
		end else if (round_en) begin
			w_q <= {w_new, w_q[15:1]};
			r_q <= r_next;
		end
	end

endmodule

>>> hdl/sm3_hash_core.sv
// ----------------------------------------------------------------------------
// sm3_hash_core
// SM3 hash core over a pre-padded message, one 32-bit word per transaction.
// ----------------------------------------------------------------------------
// Push one big-endian word of the padded message per transaction; first_word
// restarts the message and loads the chaining value from the IV registers,
// last_word ends it and yields exactly one result: the 256-bit digest, or
// all-zero digest parts with length_error set when the last word did not
// close a 16-word block (that partial block is dropped and is not folded into
// the chaining value). Without first_word, words continue from the current
// chaining value, which is the standard IV after reset or what the last message left.
// Engine: each word is loaded into the expansion window as it is taken and,
// after the sixteenth word of a block, the rounds run on a single round unit,
// one round per cycle, with the feed-forward folded into the last round; no
// word is taken while rounds run. A digest then goes through the emit state,
// which waits until the output register is free. A short-message error
// result is produced in the cycle its word leaves the queue. The input queue
// (QUEUE_DEPTH words) lets the host keep pushing while rounds run, and the
// output register lets the next words load while a result waits to be
// popped. No clearing pass is needed after reset. IV registers are written
// through cfg_we/cfg_index/cfg_data and should only change while idle.
// ----------------------------------------------------------------------------
module sm3_hash_core #(
	parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// message words
	input  logic                              push,
	output logic                              full,
	input  sm3_pkg::sm3_in_t                  msg,
	// results
	output logic                              empty,
	input  logic                              pop,
	output sm3_pkg::sm3_out_t                 digest,
	// IV register writes
	input  logic                              cfg_we,
	input  logic [sm3_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data
);

	sm3_pkg::state_t    iv_q;
	logic               item_valid;
	logic               item_ready;
	sm3_pkg::sm3_item_t item;

	// IV registers, reset to the standard SM3 IV
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q <= sm3_pkg::IV_STD;
		end else if (cfg_we) begin
			iv_q[cfg_index] <= cfg_data;
		end
	end

	// front: position tracking, classification, word queue
	sm3_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.msg        (msg),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// back: expansion, rounds, feed-forward, result register
	sm3_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.iv         (iv_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.digest     (digest)
	);

	// a first word restarts the position, so it can never close a block
	a_first_not_complete: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item.first |->
			(item.kind != sm3_pkg::KIND_BLOCK) && (item.kind != sm3_pkg::KIND_DIGEST))
		else $error("first word classified as block end");

	// after an accepted word the queue presents a valid item on the next cycle
	a_push_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> item_valid)
		else $error("accepted word missing from queue");

	// error results carry an all-zero digest
	a_error_zero_digest: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && digest.length_error |->
			(digest.digest_part_0 == '0) && (digest.digest_part_1 == '0) &&
			(digest.digest_part_2 == '0) && (digest.digest_part_3 == '0))
		else $error("length error result with nonzero digest");

endmodule
